// ===== rtl/ole_pkg.sv =====
// shared types and constants for the ordered list engine
// no dependencies; imported by ole_cell and ordered_list_engine_unit
`default_nettype none

package ole_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned LEN_W    = 5;
  // wide enough to hold the count itself
  localparam int unsigned IDX_W    = $clog2(CAPACITY + 1);

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RMV_FRONT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RMV_BACK  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RMV_VALUE = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL
  } ole_op_e;

  // command broadcast to every cell of the row
  typedef struct packed {
    ole_op_e                  op;
    logic                     by_value;
    logic [IDX_W-1:0]         idx;
    logic [IDX_W-1:0]         count;
    logic signed [WORD_W-1:0] word;
  } ole_bcast_t;

endpackage

`default_nettype wire

// ===== rtl/ole_cell.sv =====
// one slot of the list row: holds a word, shifts left or right, compares
// depends on ole_pkg
`default_nettype none

module ole_cell (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire ole_pkg::ole_bcast_t        bcast_i,
  input  wire [ole_pkg::IDX_W-1:0]        cell_idx_i,
  input  wire signed [ole_pkg::WORD_W-1:0] left_i,
  input  wire signed [ole_pkg::WORD_W-1:0] right_i,
  input  wire                             chain_i,
  output logic                            chain_o,
  output logic signed [ole_pkg::WORD_W-1:0] data_o,
  output logic signed [ole_pkg::WORD_W-1:0] sel_o
);
  import ole_pkg::*;

  logic signed [WORD_W-1:0] data_q, data_d;
  logic                     occupied;
  logic                     match;
  logic                     hit;

  assign occupied = (cell_idx_i < bcast_i.count);
  assign match    = occupied && (data_q == bcast_i.word);

  // by value: first matching slot; otherwise the slot at the given index
  always_comb begin
    if (bcast_i.op == OP_HOLD) begin
      hit = 1'b0;
    end else if (bcast_i.by_value) begin
      hit = match && !chain_i;
    end else begin
      hit = (cell_idx_i == bcast_i.idx);
    end
  end

  assign chain_o = chain_i | hit;
  assign sel_o   = hit ? data_q : '0;
  assign data_o  = data_q;

  always_comb begin
    data_d = data_q;
    case (bcast_i.op)
      OP_INS: begin
        if (hit) begin
          data_d = bcast_i.word;
        end else if (chain_i) begin
          data_d = left_i;
        end
      end
      OP_DEL: begin
        if (chain_i || hit) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ordered_list_engine_unit.sv =====
// top level of the ordered list engine: command decode, row of cells, result register
// depends on ole_pkg and ole_cell
// usage:
//   in channel (in_valid_i/in_ready_o) carries one command beat: cmd_i, data_in_i,
//   position_i. out channel (out_valid_o/out_ready_i) returns one result beat per
//   command: status_o, removed_data_o, length_o.
//   every command is done at the accepting edge: the whole row of cells compares and
//   shifts at that edge, and the result appears in the output register
//   in the cycle after acceptance.
//   throughput is one command per cycle while the receiver takes results; the output register is the only stage,
//   so a new beat is taken while the previous result is being taken.
//   if the receiver stalls, the result holds and in_ready_o drops until it goes.
//   reset empties the list, zeroes every slot and drops out_valid_o.
//   the first-match search for remove value ripples through the cells as a
//   one-bit chain, which sets the critical path (CAPACITY cells long).
`default_nettype none

module ordered_list_engine_unit (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire [ole_pkg::CMD_W-1:0]           cmd_i,
  input  wire signed [ole_pkg::WORD_W-1:0]   data_in_i,
  input  wire [ole_pkg::POS_W-1:0]           position_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [ole_pkg::STAT_W-1:0]         status_o,
  output logic signed [ole_pkg::WORD_W-1:0]  removed_data_o,
  output logic [ole_pkg::LEN_W-1:0]          length_o
);
  import ole_pkg::*;

  logic                     in_fire;
  logic [IDX_W-1:0]         count_q, count_d;
  ole_bcast_t               bcast;
  logic [STAT_W-1:0]        status_base;
  logic                     search_miss;
  logic [STAT_W-1:0]        status;
  logic                     pos_past_end;
  logic                     is_del;

  // row wiring
  logic signed [WORD_W-1:0] cell_data [CAPACITY];
  logic signed [WORD_W-1:0] cell_sel  [CAPACITY];
  logic                     chain     [CAPACITY+1];
  logic signed [WORD_W-1:0] removed;

  // result register
  logic                     out_valid_q;
  logic [STAT_W-1:0]        status_q;
  logic signed [WORD_W-1:0] removed_q;
  logic [LEN_W-1:0]         length_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign pos_past_end = (32'(position_i) >= 32'(count_q));

  // command decode into one broadcast for the row
  always_comb begin
    bcast.op       = OP_HOLD;
    bcast.by_value = 1'b0;
    bcast.idx      = '0;
    bcast.count    = count_q;
    bcast.word     = data_in_i;
    status_base    = ST_OK;
    case (cmd_i)
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
        if (32'(count_q) >= CAPACITY) begin
          status_base = ST_FULL;
        end else begin
          bcast.op = OP_INS;
          if (cmd_i == CMD_INS_FRONT) begin
            bcast.idx = '0;
          end else if (cmd_i == CMD_INS_BACK || pos_past_end) begin
            bcast.idx = count_q;
          end else begin
            bcast.idx = IDX_W'(position_i);
          end
        end
      end
      CMD_RMV_FRONT, CMD_RMV_BACK: begin
        if (count_q == '0) begin
          status_base = ST_MISS;
        end else begin
          bcast.op  = OP_DEL;
          bcast.idx = (cmd_i == CMD_RMV_FRONT) ? '0 : (count_q - 1'b1);
        end
      end
      CMD_RMV_VALUE: begin
        bcast.op       = OP_DEL;
        bcast.by_value = 1'b1;
      end
      default: status_base = ST_OK;
    endcase
    // no shift unless a beat is taken
    if (!in_fire) begin
      bcast.op = OP_HOLD;
    end
  end

  // the search outcome comes back from the end of the chain
  assign search_miss = bcast.by_value && !chain[CAPACITY];
  assign status      = search_miss ? ST_MISS : status_base;

  assign is_del = (bcast.op == OP_DEL) && (status == ST_OK);

  always_comb begin
    count_d = count_q;
    if (bcast.op == OP_INS) begin
      count_d = count_q + 1'b1;
    end else if (is_del) begin
      count_d = count_q - 1'b1;
    end
  end

  // row of cells; the ends see zero so emptied slots stay cleared
  assign chain[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WORD_W-1:0] left, right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_r
      assign right = cell_data[i+1];
    end

    ole_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .bcast_i    (bcast),
      .cell_idx_i (IDX_W'(i)),
      .left_i     (left),
      .right_i    (right),
      .chain_i    (chain[i]),
      .chain_o    (chain[i+1]),
      .data_o     (cell_data[i]),
      .sel_o      (cell_sel[i])
    );
  end

  // only the hit cell drives a non-zero word
  always_comb begin
    removed = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed = removed | cell_sel[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      removed_q   <= '0;
      length_q    <= '0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
        status_q    <= status;
        removed_q   <= is_del ? removed : '0;
        length_q    <= LEN_W'(count_d);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign removed_data_o = removed_q;
  assign length_o       = length_q;

endmodule

`default_nettype wire
